/* hdl/spatial_bucket_table_defines.svh */
// assertion macros for the spatial bucket table
`ifndef SPATIAL_BUCKET_TABLE_DEFINES_SVH
`define SPATIAL_BUCKET_TABLE_DEFINES_SVH

`ifndef SYNTH
// property checked at every rising edge, suspended while reset is high
`define SBT_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// property checked at every rising edge, reset included
`define SBT_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBT_ASSERT(label, clk, rst, prop, msg)
`define SBT_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

/* hdl/sbt_pkg.sv */
`timescale 1ns / 1ps

package sbt_pkg;

  // default geometry
  localparam int CELLS_DEF    = 4096;
  localparam int SLOTS_DEF    = 8;
  localparam int ENTITIES_DEF = 1024;

  // field widths
  localparam int KIND_W   = 2;
  localparam int ENT_W    = 10;
  localparam int CELL_W   = 12;
  localparam int STATUS_W = 3;
  localparam int NSLOT_W  = 3;
  localparam int POP_W    = 11;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MOVE   = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IN_CELL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SAME_CELL   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PLACED      = 3'd4;

endpackage

/* hdl/sbt_channels.sv */
`timescale 1ns / 1ps

// request channel
interface sbt_req_if;
  logic                       valid;
  logic                       ready;
  logic [sbt_pkg::KIND_W-1:0] kind;
  logic [sbt_pkg::ENT_W-1:0]  entity_id;
  logic [sbt_pkg::CELL_W-1:0] from_cell;
  logic [sbt_pkg::CELL_W-1:0] to_cell;

  modport source (output valid, kind, entity_id, from_cell, to_cell, input ready);
  modport sink (input valid, kind, entity_id, from_cell, to_cell, output ready);
endinterface

// result channel
interface sbt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sbt_pkg::STATUS_W-1:0] status;
  logic [sbt_pkg::NSLOT_W-1:0]  new_slot;
  logic [sbt_pkg::POP_W-1:0]    population;

  modport source (output valid, status, new_slot, population, input ready);
  modport sink (input valid, status, new_slot, population, output ready);
endinterface

/* hdl/sbt_ram.sv */
`timescale 1ns / 1ps

// one write port, one read port, registered read data
module sbt_ram #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/spatial_bucket_table.sv */
`timescale 1ns / 1ps
// spatial bucket table: a grid of cell buckets with swap-remove and back-pointers
// req channel: kind (add, remove, move), entity_id, from_cell, to_cell
// rsp channel: status, new_slot, population, one result per request
// a transfer happens when valid and ready are both high at a rising clock edge
// after reset the block sweeps the bucket fill counts and placed flags to zero,
// one entry a cycle over max(CELLS, ENTITIES) entries (4096 with the defaults);
// req.ready stays low during the sweep
// one request is worked on at a time, req.ready is high only when idle
// add, kind three and every rejected request: the result is loaded from the first
// pass once the output register has room, and the block then returns to idle
// remove and move: a second pass through the bucket memory follows the first
// the passes follow a read-then-write sequence through the fill, entry and
// back-pointer memories
// the result sits in an output register; a new request is taken while it waits,
// and if the receiver stalls the next request holds before its final writes

`include "spatial_bucket_table_defines.svh"

module spatial_bucket_table #(
  parameter int CELLS    = sbt_pkg::CELLS_DEF,
  parameter int SLOTS    = sbt_pkg::SLOTS_DEF,
  parameter int ENTITIES = sbt_pkg::ENTITIES_DEF
) (
  input logic       clk,
  input logic       rst,
  sbt_req_if.sink   req,
  sbt_rsp_if.source rsp
);

  localparam int CIDX_W   = $clog2(CELLS);
  localparam int EIDX_W   = $clog2(ENTITIES);
  localparam int SW       = $clog2(SLOTS);
  localparam int FW       = $clog2(SLOTS + 1);
  localparam int EA_DEPTH = CELLS * SLOTS;
  localparam int EA_W     = $clog2(EA_DEPTH);
  localparam int HOME_W   = 1 + sbt_pkg::CELL_W + SW;
  localparam int CLR_N    = (CELLS > ENTITIES) ? CELLS : ENTITIES;
  localparam int CLR_W    = $clog2(CLR_N);

  // sequencer states
  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_P1    = 2'd2;
  localparam logic [1:0] S_P2    = 2'd3;

  // flat address of one slot in the entry memory
  function automatic logic [EA_W-1:0] eaddr(input logic [CIDX_W-1:0] c,
                                            input logic [SW-1:0] s);
    return EA_W'(c) * EA_W'(SLOTS) + EA_W'(s);
  endfunction

  logic [1:0]       state, state_next;
  logic [CLR_W-1:0] clr_idx;

  // latched request
  logic [sbt_pkg::KIND_W-1:0] r_kind;
  logic [sbt_pkg::ENT_W-1:0]  r_ent;
  logic [sbt_pkg::CELL_W-1:0] r_from;
  logic [sbt_pkg::CELL_W-1:0] r_to;

  logic [sbt_pkg::POP_W-1:0] pop, pop_next;

  // output register
  logic                         out_valid;
  logic [sbt_pkg::STATUS_W-1:0] out_status;
  logic [sbt_pkg::NSLOT_W-1:0]  out_slot;
  logic [sbt_pkg::POP_W-1:0]    out_pop;

  // memory ports
  logic              accept;
  logic              fill_we;
  logic [CIDX_W-1:0] fill_waddr;
  logic [FW-1:0]     fill_wdata;
  logic [FW-1:0]     fill_to_rd, fill_from_rd;
  logic              ent_we, ent_re;
  logic [EA_W-1:0]   ent_waddr, ent_raddr;
  logic [sbt_pkg::ENT_W-1:0] ent_wdata, moved;
  logic              home_we;
  logic [EIDX_W-1:0] home_waddr;
  logic [HOME_W-1:0] home_wdata, home_rdata;

  // decode of the read-back state
  logic                       h_placed;
  logic [sbt_pkg::CELL_W-1:0] h_cell;
  logic [SW-1:0]              h_slot;
  logic ent_ok, from_in, to_in, to_ok, is_home;
  logic do_add, do_take, add_go, can_finish, finish;
  logic [sbt_pkg::STATUS_W-1:0] p1_status, fin_status;
  logic [sbt_pkg::NSLOT_W-1:0]  fin_slot;

  assign accept     = req.valid && req.ready;
  assign req.ready  = (state == S_IDLE);
  assign can_finish = !out_valid || rsp.ready;

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.new_slot   = out_slot;
  assign rsp.population = out_pop;

  // fill counts: two copies written alike give two read ports (target, source)
  sbt_ram #(.DEPTH(CELLS), .WIDTH(FW)) u_fill_to (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (accept),
    .raddr (CIDX_W'(req.to_cell)),
    .rdata (fill_to_rd)
  );

  sbt_ram #(.DEPTH(CELLS), .WIDTH(FW)) u_fill_from (
    .clk   (clk),
    .we    (fill_we),
    .waddr (fill_waddr),
    .wdata (fill_wdata),
    .re    (accept),
    .raddr (CIDX_W'(req.from_cell)),
    .rdata (fill_from_rd)
  );

  // bucket entries, packed densely from slot 0 in each cell
  sbt_ram #(.DEPTH(EA_DEPTH), .WIDTH(sbt_pkg::ENT_W)) u_entries (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (moved)
  );

  // back-pointers: placed flag, home cell, home slot
  sbt_ram #(.DEPTH(ENTITIES), .WIDTH(HOME_W)) u_home (
    .clk   (clk),
    .we    (home_we),
    .waddr (home_waddr),
    .wdata (home_wdata),
    .re    (accept),
    .raddr (EIDX_W'(req.entity_id)),
    .rdata (home_rdata)
  );

  assign {h_placed, h_cell, h_slot} = home_rdata;

  // range and membership checks on the read-back state
  assign ent_ok  = 32'(r_ent) < ENTITIES;
  assign from_in = 32'(r_from) < CELLS;
  assign to_in   = 32'(r_to) < CELLS;
  assign to_ok   = to_in && (32'(fill_to_rd) < SLOTS);
  assign is_home = ent_ok && h_placed && from_in && (h_cell == r_from);

  always_comb begin
    p1_status = sbt_pkg::ST_OK;
    do_add    = 1'b0;
    do_take   = 1'b0;
    case (r_kind)
      sbt_pkg::KIND_ADD: begin
        if (ent_ok && h_placed) begin
          p1_status = sbt_pkg::ST_PLACED;
        end else if (!ent_ok || !to_ok) begin
          p1_status = sbt_pkg::ST_FULL;
        end else begin
          do_add = 1'b1;
        end
      end
      sbt_pkg::KIND_REMOVE: begin
        if (!is_home) begin
          p1_status = sbt_pkg::ST_NOT_IN_CELL;
        end else begin
          do_take = 1'b1;
        end
      end
      sbt_pkg::KIND_MOVE: begin
        if (!is_home) begin
          p1_status = sbt_pkg::ST_NOT_IN_CELL;
        end else if (r_from == r_to) begin
          p1_status = sbt_pkg::ST_SAME_CELL;
        end else if (!to_ok) begin
          p1_status = sbt_pkg::ST_FULL;
        end else begin
          do_add  = 1'b1;
          do_take = 1'b1;
        end
      end
      default: begin
        p1_status = sbt_pkg::ST_OK;
      end
    endcase
  end

  // the add half commits in the first pass; a plain add waits for output room
  assign add_go = (state == S_P1) && do_add && (do_take || can_finish);

  always_comb begin
    state_next = state;
    finish     = 1'b0;
    fin_status = sbt_pkg::ST_OK;
    fin_slot   = '0;
    pop_next   = pop;
    fill_we    = 1'b0;
    fill_waddr = '0;
    fill_wdata = '0;
    ent_we     = 1'b0;
    ent_waddr  = '0;
    ent_wdata  = '0;
    ent_re     = 1'b0;
    ent_raddr  = '0;
    home_we    = 1'b0;
    home_waddr = '0;
    home_wdata = '0;
    case (state)
      S_CLEAR: begin
        // zero fill counts and placed flags
        fill_we    = 32'(clr_idx) < CELLS;
        fill_waddr = CIDX_W'(clr_idx);
        home_we    = 32'(clr_idx) < ENTITIES;
        home_waddr = EIDX_W'(clr_idx);
        if (32'(clr_idx) == CLR_N - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_P1;
        end
      end
      S_P1: begin
        if (add_go) begin
          // append to the target bucket and point the entity at it
          ent_we     = 1'b1;
          ent_waddr  = eaddr(CIDX_W'(r_to), SW'(fill_to_rd));
          ent_wdata  = r_ent;
          fill_we    = 1'b1;
          fill_waddr = CIDX_W'(r_to);
          fill_wdata = fill_to_rd + FW'(1);
          home_we    = 1'b1;
          home_waddr = EIDX_W'(r_ent);
          home_wdata = {1'b1, r_to, SW'(fill_to_rd)};
        end
        if (do_take) begin
          // fetch the last entry of the source bucket
          ent_re    = 1'b1;
          ent_raddr = eaddr(CIDX_W'(r_from), SW'(fill_from_rd - FW'(1)));
          if (!do_add) begin
            home_we    = 1'b1;
            home_waddr = EIDX_W'(r_ent);
            home_wdata = '0;
            pop_next   = pop - sbt_pkg::POP_W'(1);
          end
          state_next = S_P2;
        end else if (can_finish) begin
          if (do_add) begin
            pop_next = pop + sbt_pkg::POP_W'(1);
          end
          finish     = 1'b1;
          fin_status = p1_status;
          fin_slot   = do_add ? sbt_pkg::NSLOT_W'(fill_to_rd) : '0;
          state_next = S_IDLE;
        end
      end
      S_P2: begin
        if (can_finish) begin
          // swap the last entry into the vacated slot and shrink the bucket
          ent_we     = 1'b1;
          ent_waddr  = eaddr(CIDX_W'(r_from), h_slot);
          ent_wdata  = moved;
          fill_we    = 1'b1;
          fill_waddr = CIDX_W'(r_from);
          fill_wdata = fill_from_rd - FW'(1);
          if (moved != r_ent && 32'(moved) < ENTITIES) begin
            home_we    = 1'b1;
            home_waddr = EIDX_W'(moved);
            home_wdata = {1'b1, r_from, h_slot};
          end
          finish     = 1'b1;
          fin_status = sbt_pkg::ST_OK;
          fin_slot   = (r_kind == sbt_pkg::KIND_MOVE) ? sbt_pkg::NSLOT_W'(fill_to_rd) : '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      pop     <= '0;
    end else begin
      state <= state_next;
      pop   <= pop_next;
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + CLR_W'(1);
      end
    end
  end

  // request latch, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      r_kind <= req.kind;
      r_ent  <= req.entity_id;
      r_from <= req.from_cell;
      r_to   <= req.to_cell;
    end
  end

  // output register: held until the receiver takes the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status <= fin_status;
      out_slot   <= fin_slot;
      out_pop    <= pop_next;
    end
  end

  `SBT_ASSERT(a_pop_bound, clk, rst, 32'(pop) <= ENTITIES, "population above entity count")
  `SBT_ASSERT(a_accept_p1, clk, rst, accept |=> (state == S_P1), "accepted request not in first pass")
  `SBT_ASSERT(a_finish_room, clk, rst, finish |-> can_finish, "result written over an untaken result")
  `SBT_ASSERT(a_fill_bound, clk, rst, fill_we |-> (32'(fill_wdata) <= SLOTS), "bucket fill beyond slot count")
  `SBT_ASSERT(a_p2_take, clk, rst, (state == S_P2) |-> $past(do_take), "second pass without a remove")

endmodule

/* dv/spatial_bucket_table_test.sv */
`timescale 1ns / 1ps

module spatial_bucket_table_test;

  // geometry of the instance under test
  localparam int CELLS    = sbt_pkg::CELLS_DEF;
  localparam int SLOTS    = sbt_pkg::SLOTS_DEF;
  localparam int ENTITIES = sbt_pkg::ENTITIES_DEF;

  // the fourth request kind is ignored by the block but still answered
  localparam logic [sbt_pkg::KIND_W-1:0] KIND_IGNORED = 2'd3;

  // the limit covers the reset sweep of max(CELLS, ENTITIES) entries with generous margin
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_ITEMS   = 426;
  localparam int CALM_ITEMS     = 100;
  localparam int HOT_CELLS      = 8;

  typedef struct packed {
    logic [sbt_pkg::STATUS_W-1:0] status;
    logic [sbt_pkg::NSLOT_W-1:0]  new_slot;
    logic [sbt_pkg::POP_W-1:0]    population;
  } table_result_t;

  logic clk = 1'b0;
  logic rst;

  sbt_req_if req_ch ();
  sbt_rsp_if rsp_ch ();

  spatial_bucket_table #(
    .CELLS    (CELLS),
    .SLOTS    (SLOTS),
    .ENTITIES (ENTITIES)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the table, advanced once per accepted request
  // ---------------------------------------------------------------------------
  logic [3:0]                   cell_fill  [CELLS];
  logic [sbt_pkg::ENT_W-1:0]    slot_owner [CELLS*SLOTS];
  logic [sbt_pkg::CELL_W-1:0]   ent_cell   [ENTITIES];
  logic [sbt_pkg::NSLOT_W-1:0]  ent_slot   [ENTITIES];
  logic                         ent_placed [ENTITIES];
  logic [sbt_pkg::POP_W-1:0]    placed_count;

  // ids currently sitting in some bucket, used to build well-formed requests
  int                  placed_ids [$];

  // results predicted but not yet seen on the result channel, oldest first
  table_result_t       pending_results [$];

  int                  status_tally [5];
  int                  requests_sent;
  int                  results_seen = 0;
  int                  mismatch_count = 0;
  int                  unexpected_count = 0;
  int                  cycle_count = 0;
  bit                  gaps_on;

  // append ent to the bucket, returns the slot it lands in
  function automatic logic [sbt_pkg::NSLOT_W-1:0] place_entity(
      logic [sbt_pkg::ENT_W-1:0] ent, logic [sbt_pkg::CELL_W-1:0] bucket);
    logic [sbt_pkg::NSLOT_W-1:0] slot;
    slot = cell_fill[bucket][sbt_pkg::NSLOT_W-1:0];
    slot_owner[bucket*SLOTS + slot] = ent;
    cell_fill[bucket] = cell_fill[bucket] + 4'd1;
    ent_cell[ent] = bucket;
    ent_slot[ent] = slot;
    ent_placed[ent] = 1'b1;
    placed_count = placed_count + 1'b1;
    placed_ids = {placed_ids, int'(ent)};
    return slot;
  endfunction

  // swap-remove: the last entry of the bucket fills the hole left by ent
  function automatic void evict_entity(logic [sbt_pkg::ENT_W-1:0] ent,
                                       logic [sbt_pkg::CELL_W-1:0] bucket);
    logic [sbt_pkg::NSLOT_W-1:0] slot;
    logic [3:0]                  last;
    logic [sbt_pkg::ENT_W-1:0]   moved;
    int                          hits [$];
    slot  = ent_slot[ent];
    last  = cell_fill[bucket] - 4'd1;
    moved = slot_owner[bucket*SLOTS + last];
    slot_owner[bucket*SLOTS + slot] = moved;
    cell_fill[bucket] = last;
    if (moved != ent) begin
      ent_slot[moved] = slot;
    end
    ent_placed[ent] = 1'b0;
    placed_count = placed_count - 1'b1;
    hits = placed_ids.find_first_index(x) with (x == ent);
    placed_ids.delete(hits[0]);
  endfunction

  function automatic table_result_t apply_request(logic [sbt_pkg::KIND_W-1:0] kind,
                                                  logic [sbt_pkg::ENT_W-1:0]  ent,
                                                  logic [sbt_pkg::CELL_W-1:0] from,
                                                  logic [sbt_pkg::CELL_W-1:0] to);
    table_result_t res;
    logic          at_home;
    res.status   = sbt_pkg::ST_OK;
    res.new_slot = '0;
    at_home = ent_placed[ent] && (ent_cell[ent] == from);
    case (kind)
      sbt_pkg::KIND_ADD: begin
        if (ent_placed[ent]) begin
          res.status = sbt_pkg::ST_PLACED;
        end else if (cell_fill[to] >= SLOTS) begin
          res.status = sbt_pkg::ST_FULL;
        end else begin
          res.new_slot = place_entity(ent, to);
        end
      end
      sbt_pkg::KIND_REMOVE: begin
        if (!at_home) begin
          res.status = sbt_pkg::ST_NOT_IN_CELL;
        end else begin
          evict_entity(ent, from);
        end
      end
      sbt_pkg::KIND_MOVE: begin
        // home check first, then same cell, then room in the target
        if (!at_home) begin
          res.status = sbt_pkg::ST_NOT_IN_CELL;
        end else if (from == to) begin
          res.status = sbt_pkg::ST_SAME_CELL;
        end else if (cell_fill[to] >= SLOTS) begin
          res.status = sbt_pkg::ST_FULL;
        end else begin
          evict_entity(ent, from);
          res.new_slot = place_entity(ent, to);
        end
      end
      default: begin
        // ignored kind: ok, slot zero, population unchanged
      end
    endcase
    res.population = placed_count;
    status_tally[res.status]++;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // idle gaps: mostly none or short, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (!gaps_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // request side: one transfer per call, predicted at the accepting edge
  // valid is left high after a transfer so back-to-back requests need no
  // second assignment in the same step
  // ---------------------------------------------------------------------------
  task automatic send_request(logic [sbt_pkg::KIND_W-1:0] kind,
                              logic [sbt_pkg::ENT_W-1:0] ent,
                              logic [sbt_pkg::CELL_W-1:0] from,
                              logic [sbt_pkg::CELL_W-1:0] to);
    int            gap;
    table_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.entity_id <= ent;
    req_ch.from_cell <= from;
    req_ch.to_cell   <= to;
    // ready is read right after the edge, i.e. the value the edge saw
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    res = apply_request(kind, ent, from, to);
    pending_results = {pending_results, res};
    requests_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls on ready, one assignment per edge
  // ---------------------------------------------------------------------------
  int stall_left;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (gaps_on && $urandom_range(0, 99) < 20) begin
        stall_left <= pick_gap();
      end
    end
  end

  // compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    table_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (mismatch_count + unexpected_count <= MAX_REPORTS) begin
          $display("unexpected result: status %0d slot %0d population %0d",
                   rsp_ch.status, rsp_ch.new_slot, rsp_ch.population);
        end
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.status !== want.status || rsp_ch.new_slot !== want.new_slot ||
            rsp_ch.population !== want.population) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= MAX_REPORTS) begin
            $display("result %0d mismatch: status %0d/%0d slot %0d/%0d pop %0d/%0d",
                     results_seen, want.status, rsp_ch.status, want.new_slot,
                     rsp_ch.new_slot, want.population, rsp_ch.population);
          end
        end
      end
    end
  end

  // watchdog, also covers the clearing sweep after reset
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // fill the top cell to capacity with the extreme ids, then overflow it
  task automatic test_fill_and_overflow();
    send_request(sbt_pkg::KIND_ADD, 10'd1023, '0, 12'd4095);
    for (int e = 0; e < SLOTS - 1; e++) begin
      send_request(sbt_pkg::KIND_ADD, sbt_pkg::ENT_W'(e), '0, 12'd4095);
    end
    send_request(sbt_pkg::KIND_ADD, 10'd512, '0, 12'd4095);
    // already placed wins over a free target
    send_request(sbt_pkg::KIND_ADD, 10'd1023, '0, 12'd0);
  endtask

  // rejects that must leave the table untouched
  task automatic test_rejects();
    send_request(sbt_pkg::KIND_REMOVE, 10'd1023, 12'd0, '0);
    send_request(sbt_pkg::KIND_REMOVE, 10'd700, 12'd4095, '0);
    send_request(sbt_pkg::KIND_MOVE, 10'd0, 12'd4095, 12'd4095);
    send_request(sbt_pkg::KIND_MOVE, 10'd100, 12'd0, 12'd1);
  endtask

  // swap-remove from middle and first slots, moves both ways (the one into the full top cell is refused)
  task automatic test_swap_remove();
    send_request(sbt_pkg::KIND_ADD, 10'd7, '0, 12'd0);
    send_request(sbt_pkg::KIND_MOVE, 10'd7, 12'd0, 12'd4095);
    send_request(sbt_pkg::KIND_REMOVE, 10'd2, 12'd4095, '0);
    send_request(sbt_pkg::KIND_MOVE, 10'd6, 12'd4095, 12'd0);
    send_request(sbt_pkg::KIND_MOVE, 10'd1023, 12'd4095, 12'd0);
    send_request(sbt_pkg::KIND_REMOVE, 10'd7, 12'd0, '0);
    send_request(sbt_pkg::KIND_REMOVE, 10'd1023, 12'd0, '0);
    send_request(sbt_pkg::KIND_ADD, 10'd2, '0, 12'd4095);
  endtask

  task automatic test_ignored_kind();
    send_request(KIND_IGNORED, '1, '1, '1);
    send_request(KIND_IGNORED, '0, '0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly well-formed requests on a few hot cells so buckets
  // fill up and swap-removes hit every slot, plus some full-range noise
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(int count);
    logic [sbt_pkg::CELL_W-1:0] hot [HOT_CELLS];
    logic [sbt_pkg::KIND_W-1:0] kind;
    logic [sbt_pkg::ENT_W-1:0]  ent;
    logic [sbt_pkg::CELL_W-1:0] from;
    logic [sbt_pkg::CELL_W-1:0] to;
    int                         r;
    hot[0] = '0;
    hot[1] = '1;
    for (int h = 2; h < HOT_CELLS; h++) begin
      hot[h] = sbt_pkg::CELL_W'($urandom_range(0, CELLS - 1));
    end
    for (int n = 0; n < count; n++) begin
      // the first stretch runs with no idling on either side
      gaps_on = (n >= CALM_ITEMS);
      r    = $urandom_range(0, 99);
      from = hot[$urandom_range(0, HOT_CELLS - 1)];
      to   = hot[$urandom_range(0, HOT_CELLS - 1)];
      if (r < 8) begin
        kind = sbt_pkg::KIND_W'($urandom_range(0, 3));
        ent  = sbt_pkg::ENT_W'($urandom);
        from = sbt_pkg::CELL_W'($urandom);
        to   = sbt_pkg::CELL_W'($urandom);
      end else if (r < 45 || placed_ids.size() == 0) begin
        kind = sbt_pkg::KIND_ADD;
        if (placed_ids.size() > 0 && $urandom_range(0, 9) == 0) begin
          ent = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
        end else begin
          do ent = sbt_pkg::ENT_W'($urandom_range(0, ENTITIES - 1)); while (ent_placed[ent]);
        end
      end else begin
        ent  = placed_ids[$urandom_range(0, placed_ids.size() - 1)];
        kind = (r < 70) ? sbt_pkg::KIND_REMOVE : sbt_pkg::KIND_MOVE;
        if ($urandom_range(0, 99) >= 15) begin
          from = ent_cell[ent];
        end
        if (kind == sbt_pkg::KIND_MOVE && $urandom_range(0, 9) == 0) begin
          to = from;
        end
      end
      send_request(kind, ent, from, to);
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.kind         = '0;
    req_ch.entity_id    = '0;
    req_ch.from_cell    = '0;
    req_ch.to_cell      = '0;
    placed_count        = '0;
    requests_sent       = 0;
    gaps_on             = 1'b1;
    for (int c = 0; c < CELLS; c++) begin
      cell_fill[c] = '0;
    end
    for (int e = 0; e < ENTITIES; e++) begin
      ent_placed[e] = 1'b0;
    end
    for (int s = 0; s < 5; s++) begin
      status_tally[s] = 0;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // the block holds ready low through its clearing sweep
    test_fill_and_overflow();
    test_rejects();
    test_swap_remove();
    test_ignored_kind();
    test_random_traffic(RANDOM_ITEMS);
    gaps_on = 1'b1;
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d requests, %0d results; ok %0d, full %0d, not in cell %0d",
             requests_sent, results_seen, status_tally[sbt_pkg::ST_OK],
             status_tally[sbt_pkg::ST_FULL], status_tally[sbt_pkg::ST_NOT_IN_CELL]);
    $display("same cell %0d, already placed %0d; mismatches %0d, unexpected %0d",
             status_tally[sbt_pkg::ST_SAME_CELL], status_tally[sbt_pkg::ST_PLACED],
             mismatch_count, unexpected_count);
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/sbt_pkg.sv
hdl/sbt_channels.sv
hdl/sbt_ram.sv
hdl/spatial_bucket_table.sv
dv/spatial_bucket_table_test.sv
